// ===== hw/rtl/pwlt_pkg.sv =====
// Package with the segment tables and shared types of the tanh approximation.
package pwlt_pkg;

    localparam int SEG_COUNT = 16;
    localparam int SEG_W     = 4;
    localparam int EDGE_W    = 16;
    localparam int MAG_W     = 15;
    localparam int SLOPE_W   = 16;
    localparam int BIAS_W    = 15;
    localparam int PROD_W    = SLOPE_W + MAG_W;
    localparam int QUOT_W    = PROD_W - 10;
    localparam int RES_W     = QUOT_W + 2;
    localparam int DATA_W    = 16;

    localparam logic [MAG_W-1:0] MAG_LIMIT = 15'h7FFF;

    typedef enum logic [1:0]
    {
        SHIFT_11,
        SHIFT_12,
        SHIFT_14,
        SHIFT_18
    } shift_sel_t;

    typedef struct packed
    {
        logic              neg;
        logic [MAG_W-1:0]  mag;
        logic [SEG_W-1:0]  seg;
    } seg_info_t;

    // Upper edge of each band; entry 0 is the lower edge of band 0.
    function automatic logic [EDGE_W-1:0] band_edge(input logic [SEG_W:0] idx);
        logic [EDGE_W-1:0] e;
        case (idx)
            5'd0:    e = 16'd0;
            5'd1:    e = 16'd512;
            5'd2:    e = 16'd888;
            5'd3:    e = 16'd1226;
            5'd4:    e = 16'd1558;
            5'd5:    e = 16'd1899;
            5'd6:    e = 16'd2264;
            5'd7:    e = 16'd2670;
            5'd8:    e = 16'd3146;
            5'd9:    e = 16'd3734;
            5'd10:   e = 16'd4297;
            5'd11:   e = 16'd4761;
            5'd12:   e = 16'd5466;
            5'd13:   e = 16'd6151;
            5'd14:   e = 16'd7193;
            5'd15:   e = 16'd8093;
            default: e = 16'd32768;
        endcase
        return e;
    endfunction

    function automatic logic [SLOPE_W-1:0] seg_slope(input logic [SEG_W-1:0] seg);
        logic [SLOPE_W-1:0] s;
        case (seg)
            4'd0:    s = 16'd32266;
            4'd1:    s = 16'd29154;
            4'd2:    s = 16'd25374;
            4'd3:    s = 16'd21309;
            4'd4:    s = 16'd17272;
            4'd5:    s = 16'd26886;
            4'd6:    s = 16'd19904;
            4'd7:    s = 16'd13765;
            4'd8:    s = 16'd8599;
            4'd9:    s = 16'd19497;
            4'd10:   s = 16'd12047;
            4'd11:   s = 16'd7324;
            4'd12:   s = 16'd3373;
            4'd13:   s = 16'd26820;
            4'd14:   s = 16'd5531;
            default: s = 16'd337;
        endcase
        return s;
    endfunction

    function automatic logic [BIAS_W-1:0] seg_bias(input logic [SEG_W-1:0] seg);
        logic [BIAS_W-1:0] b;
        case (seg)
            4'd0:    b = 15'd0;
            4'd1:    b = 15'd778;
            4'd2:    b = 15'd2417;
            4'd3:    b = 15'd4851;
            4'd4:    b = 15'd7922;
            4'd5:    b = 15'd11474;
            4'd6:    b = 15'd15334;
            4'd7:    b = 15'd19335;
            4'd8:    b = 15'd23303;
            4'd9:    b = 15'd26699;
            4'd10:   b = 15'd28653;
            4'd11:   b = 15'd30026;
            4'd12:   b = 15'd31344;
            4'd13:   b = 15'd31981;
            4'd14:   b = 15'd32565;
            default: b = 15'd32725;
        endcase
        return b;
    endfunction

    function automatic shift_sel_t seg_shift(input logic [SEG_W-1:0] seg);
        shift_sel_t sh;
        if (seg < 4'd5)
            sh = SHIFT_11;
        else if (seg < 4'd9)
            sh = SHIFT_12;
        else if (seg < 4'd13)
            sh = SHIFT_14;
        else
            sh = SHIFT_18;
        return sh;
    endfunction

endpackage

// ===== hw/rtl/pwlt_if.sv =====
// Stream interfaces for the sample input and the tanh result.
interface pwlt_sample_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pwlt_tanh_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  tanh_value;

    modport source (output valid, output tanh_value, input ready);
    modport sink   (input valid, input tanh_value, output ready);
endinterface

// ===== hw/rtl/pwlt_seg_find.sv =====
// Magnitude and band search for one sample.
module pwlt_seg_find
(
    input  logic signed [15:0] sample,
    output pwlt_pkg::seg_info_t info
);
    import pwlt_pkg::*;

    logic [SEG_COUNT-1:0] below;
    logic [MAG_W-1:0]     mag;
    logic [SEG_W-1:0]     seg;

    always_comb
    begin
        if (!sample[15])
            mag = sample[MAG_W-1:0];
        else if (sample[MAG_W-1:0] == '0)
            mag = MAG_LIMIT;
        else
            mag = MAG_W'(-sample);
    end

    // Compare against every upper band edge at once, then take the first band that fits.
    always_comb
    begin
        for (int i = 0; i < SEG_COUNT; i++)
            below[i] = {1'b0, mag} <= band_edge((SEG_W+1)'(i + 1));
    end

    always_comb
    begin
        seg = SEG_W'(SEG_COUNT - 1);
        for (int i = SEG_COUNT - 1; i >= 0; i--)
            if (below[i])
                seg = SEG_W'(i);
    end

    assign info.neg = sample[15];
    assign info.mag = mag;
    assign info.seg = seg;

endmodule

// ===== hw/rtl/piecewise_linear_tanh.sv =====
// Top level: three-stage pipelined piecewise linear tanh in Q15.
// Throughput: one item per cycle while the output is not stalled; stage 1
// band search, stage 2 the 16x15 slope multiply, stage 3 shift, bias and
// clamp into the output register.
// A stage holds its item while the next one is full and not advancing.
// Reset clears all valid bits; the data registers are not reset.
module piecewise_linear_tanh
(
    input  logic                   clk,
    input  logic                   rst_n,
    pwlt_sample_if.sink            samples,
    pwlt_tanh_if.source            results
);
    import pwlt_pkg::*;

    seg_info_t               info;

    logic                    s1_valid_reg, s1_valid_next;
    seg_info_t               s1_info_reg;
    logic                    s2_valid_reg, s2_valid_next;
    logic [PROD_W-1:0]       s2_prod_reg;
    logic [SEG_W-1:0]        s2_seg_reg;
    logic                    s2_neg_reg;
    logic                    s3_valid_reg, s3_valid_next;
    logic signed [DATA_W-1:0] s3_value_reg, s3_value_next;
    logic                    s3_neg_reg;

    logic                    s1_ready, s2_ready, s3_ready;
    logic [PROD_W:0]         rounded;
    logic [QUOT_W-1:0]       quot;
    logic signed [RES_W-1:0] res;

    pwlt_seg_find u_seg_find
    (
        .sample (samples.sample),
        .info   (info)
    );

    assign s3_ready      = !s3_valid_reg || results.ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign samples.ready = s1_ready;

    assign s1_valid_next = s1_ready ? samples.valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg  : s2_valid_reg;
    assign s3_valid_next = s3_ready ? s2_valid_reg  : s3_valid_reg;

    // Round towards minus infinity on the negated product: add 2^shift - 1 first.
    always_comb
    begin
        rounded = {1'b0, s2_prod_reg};
        quot    = '0;
        case (seg_shift(s2_seg_reg))
            SHIFT_11:
            begin
                if (s2_neg_reg)
                    rounded = {1'b0, s2_prod_reg} + (PROD_W+1)'((1 << 11) - 1);
                quot = QUOT_W'(rounded >> 11);
            end
            SHIFT_12:
            begin
                if (s2_neg_reg)
                    rounded = {1'b0, s2_prod_reg} + (PROD_W+1)'((1 << 12) - 1);
                quot = QUOT_W'(rounded >> 12);
            end
            SHIFT_14:
            begin
                if (s2_neg_reg)
                    rounded = {1'b0, s2_prod_reg} + (PROD_W+1)'((1 << 14) - 1);
                quot = QUOT_W'(rounded >> 14);
            end
            default:
            begin
                if (s2_neg_reg)
                    rounded = {1'b0, s2_prod_reg} + (PROD_W+1)'((1 << 18) - 1);
                quot = QUOT_W'(rounded >> 18);
            end
        endcase
    end

    always_comb
    begin
        if (s2_neg_reg)
            res = -$signed({2'b00, quot}) - $signed(RES_W'(seg_bias(s2_seg_reg)));
        else
            res = $signed({2'b00, quot}) + $signed(RES_W'(seg_bias(s2_seg_reg)));

        if (res > $signed(RES_W'(32767)))
            s3_value_next = 16'sh7FFF;
        else if (res < -$signed(RES_W'(32768)))
            s3_value_next = 16'sh8000;
        else
            s3_value_next = DATA_W'(res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && samples.valid)
            s1_info_reg <= info;
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_reg <= seg_slope(s1_info_reg.seg) * PROD_W'(s1_info_reg.mag);
            s2_seg_reg  <= s1_info_reg.seg;
            s2_neg_reg  <= s1_info_reg.neg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_value_reg <= s3_value_next;
            s3_neg_reg   <= s2_neg_reg;
        end
    end

    assign results.valid      = s3_valid_reg;
    assign results.tanh_value = s3_value_reg;

    // Band search places the magnitude inside its band.
    a_band_fits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |->
            ({1'b0, s1_info_reg.mag} <= band_edge({1'b0, s1_info_reg.seg} + 5'd1)) &&
            (s1_info_reg.seg == '0 ||
             {1'b0, s1_info_reg.mag} > band_edge({1'b0, s1_info_reg.seg})))
        else $error("magnitude outside its selected band");

    // A stalled first stage keeps its item.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(s1_info_reg))
        else $error("first stage lost its item during a stall");

    // Non-negative samples give non-negative results.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s3_neg_reg |-> !s3_value_reg[DATA_W-1])
        else $error("negative result for a non-negative sample");

    // An item moves from the multiply stage only into a free or draining output.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !results.ready |=> s3_valid_reg && $stable(s3_value_reg))
        else $error("output register overwritten while stalled");

endmodule
